// File: rtl/njk_pkg.sv
// Package for the node join and keepalive engine.
// Holds transaction structs, state and configuration structs, and code constants.
// No dependencies.
`default_nettype none

package njk_pkg;

    localparam int ADDR_BYTES = 5;
    localparam int ADDR_W     = 40;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'({(8*ADDR_BYTES){1'b1}});

    localparam logic [15:0] HELLO_DEVICE = 16'hFFFF;
    localparam logic [7:0]  RETRY_MAX    = 8'hFF;

    localparam logic [7:0] HW_TYPE_RST     = 8'hF1;
    localparam logic [7:0] FW_VERSION_RST  = 8'h00;
    localparam logic [7:0] RETRY_LIMIT_RST = 8'd10;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_MSG  = 1'b1;

    localparam logic [2:0] KIND_ACQUIRED = 3'd0;
    localparam logic [2:0] KIND_PONG     = 3'd1;
    localparam logic [2:0] KIND_SWITCH   = 3'd2;
    localparam logic [2:0] KIND_SETTINGS = 3'd3;

    localparam logic [1:0] TX_NONE  = 2'd0;
    localparam logic [1:0] TX_HELLO = 2'd1;
    localparam logic [1:0] TX_PING  = 2'd2;

    localparam logic [1:0] ADDR_NONE    = 2'd0;
    localparam logic [1:0] ADDR_SET     = 2'd1;
    localparam logic [1:0] ADDR_RESTORE = 2'd2;

    localparam logic [1:0] LED_NONE   = 2'd0;
    localparam logic [1:0] LED_JOINED = 2'd1;
    localparam logic [1:0] LED_PONG   = 2'd2;

    localparam logic [1:0] CFG_HW_TYPE     = 2'd0;
    localparam logic [1:0] CFG_FW_VERSION  = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [2:0]        msg_kind;
        logic [15:0]       msg_device;
        logic [ADDR_W-1:0] msg_addr;
        logic [7:0]        cmd_switch;
        logic [7:0]        switch_state;
        logic [15:0]       current_measure;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        tx_kind;
        logic [15:0]       tx_device;
        logic [7:0]        tx_hw_type;
        logic [7:0]        tx_version;
        logic [7:0]        tx_switch;
        logic [15:0]       tx_measure;
        logic [1:0]        addr_action;
        logic [ADDR_W-1:0] addr_value;
        logic [1:0]        led_action;
        logic              switch_apply;
        logic              settings_apply;
    } out_item_t;

    typedef struct packed {
        logic        joined;
        logic [7:0]  retry_count;
        logic [15:0] device_id;
    } njk_state_t;

    typedef struct packed {
        logic [7:0] hw_type;
        logic [7:0] fw_version;
        logic [7:0] retry_limit;
    } njk_cfg_t;

endpackage

`default_nettype wire

// File: rtl/njk_step.sv
// Per-transaction decision logic: result and next link state from one item.
// Purely combinational; depends on njk_pkg.
`default_nettype none

module njk_step (
    input  njk_pkg::in_item_t   item,
    input  njk_pkg::njk_state_t state,
    input  njk_pkg::njk_cfg_t   cfg,
    output njk_pkg::out_item_t  result,
    output njk_pkg::njk_state_t state_next
);
    import njk_pkg::*;

    logic ping_due;

    always_comb begin
        ping_due = ((item.switch_state != 8'd0) && state.retry_count[0])
                   || (state.retry_count[1:0] == 2'b11);
        result     = '0;
        state_next = state;
        if (item.req_type == REQ_TICK) begin
            if (!state.joined) begin
                result.tx_kind    = TX_HELLO;
                result.tx_device  = HELLO_DEVICE;
                result.tx_hw_type = cfg.hw_type;
                result.tx_version = cfg.fw_version;
            end else if (state.retry_count > cfg.retry_limit) begin
                result.addr_action     = ADDR_RESTORE;
                state_next.joined      = 1'b0;
                state_next.retry_count = 8'd0;
            end else begin
                if (ping_due) begin
                    result.tx_kind   = TX_PING;
                    result.tx_device = state.device_id;
                    result.tx_switch = item.switch_state;
                    result.tx_measure = (item.switch_state != 8'd0) ?
                                        item.current_measure : 16'd0;
                end
                if (state.retry_count != RETRY_MAX) begin
                    state_next.retry_count = state.retry_count + 8'd1;
                end
            end
        end else begin
            case (item.msg_kind)
                KIND_ACQUIRED: begin
                    state_next.device_id = item.msg_device;
                    state_next.joined    = 1'b1;
                    result.addr_action   = ADDR_SET;
                    result.addr_value    = item.msg_addr & ADDR_MASK;
                    result.led_action    = LED_JOINED;
                end
                KIND_PONG: begin
                    result.led_action      = LED_PONG;
                    state_next.retry_count = 8'd0;
                end
                KIND_SWITCH, KIND_SETTINGS: begin
                    state_next.retry_count = 8'd0;
                    result.switch_apply    = (item.msg_kind == KIND_SWITCH);
                    result.settings_apply  = (item.msg_kind == KIND_SETTINGS);
                    result.tx_kind         = TX_PING;
                    result.tx_device       = state.device_id;
                    result.tx_switch       = item.switch_state;
                    result.tx_measure      = (item.switch_state != 8'd0) ?
                                             item.current_measure : 16'd0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/node_join_keepalive_fsm_unit.sv
// Top level of the node join and keepalive engine.
// Holds input register, link state, configuration and result register;
// depends on njk_pkg and njk_step.
//
// Usage:
//   s_valid/s_ready/s_data carry one tick or received message per transaction.
//   m_valid/m_ready/m_data carry exactly one result per input transaction,
//   in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write hw_type (0), fw_version (1)
//   and retry_limit (2); cfg_ready is always high, other indexes are dropped.
//   Write configuration only while the block is idle.
// Timing:
//   An input transaction is held in the input register, then passes through
//   the decision logic into the result register. Throughput is one
//   transaction per cycle while m_ready stays high, set by the single pass
//   of the decision logic.
// Reset (aresetn low, synchronous): both stages empty, unjoined, retry count
//   and device id zero, configuration back to hw_type 0xF1, fw_version 0,
//   retry_limit 10.
// Stall: when m_ready is low the result holds; one more transaction is taken
//   into the input register, then s_ready drops until the result moves.
`default_nettype none

module node_join_keepalive_fsm_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  njk_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output njk_pkg::out_item_t  m_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [1:0]          cfg_index,
    input  wire  [7:0]          cfg_data
);
    import njk_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_data_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;
    njk_state_t state_reg;
    njk_cfg_t   cfg_reg;

    out_item_t  result;
    njk_state_t state_next;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    njk_step u_step (
        .item       (in_data_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .result     (result),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hw_type     <= HW_TYPE_RST;
            cfg_reg.fw_version  <= FW_VERSION_RST;
            cfg_reg.retry_limit <= RETRY_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HW_TYPE:     cfg_reg.hw_type     <= cfg_data;
                CFG_FW_VERSION:  cfg_reg.fw_version  <= cfg_data;
                CFG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/njk_checker.sv
// Port-level checker for the node join and keepalive engine, bound to the top.
// Depends on njk_pkg.
`default_nettype none

module njk_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_valid,
    input wire                s_ready,
    input njk_pkg::in_item_t  s_data,
    input wire                m_valid,
    input wire                m_ready,
    input njk_pkg::out_item_t m_data,
    input wire                cfg_valid,
    input wire                cfg_ready,
    input wire [1:0]          cfg_index,
    input wire [7:0]          cfg_data
);
    import njk_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hello_device: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_kind == TX_HELLO |->
            m_data.tx_device == HELLO_DEVICE && m_data.addr_action == ADDR_NONE)
        else $error("malformed hello");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.addr_action != ADDR_SET |-> m_data.addr_value == '0)
        else $error("address value without set action");

    a_in_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !s_ready |=> !s_ready || m_ready || !m_valid)
        else $error("input taken past a full pipeline");

endmodule

bind node_join_keepalive_fsm_unit njk_checker u_njk_checker (.*);

`default_nettype wire

// File: tb/node_join_keepalive_fsm_unit_test.sv
// Testbench for node_join_keepalive_fsm_unit: predicts every result of the join and
// keepalive engine with a scoreboard class and checks them in order, field by field.
// Depends on njk_pkg and the node_join_keepalive_fsm_unit RTL.
module node_join_keepalive_fsm_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import njk_pkg::*;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         RX_HOLD     = 80;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 14;
    localparam int         SAT_TICKS   = 260;

    class link_scoreboard;
        njk_state_t link;
        njk_cfg_t   regs;
        out_item_t  expected_replies[$];
        int         errors;

        function new();
            link             = '0;
            regs.hw_type     = HW_TYPE_RST;
            regs.fw_version  = FW_VERSION_RST;
            regs.retry_limit = RETRY_LIMIT_RST;
            errors           = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_HW_TYPE:     regs.hw_type     = val;
                CFG_FW_VERSION:  regs.fw_version  = val;
                CFG_RETRY_LIMIT: regs.retry_limit = val;
                default: ;
            endcase
        endfunction

        function out_item_t with_ping(out_item_t r, logic [7:0] sw, logic [15:0] meas);
            r.tx_kind    = TX_PING;
            r.tx_device  = link.device_id;
            r.tx_switch  = sw;
            r.tx_measure = (sw != 8'h00) ? meas : 16'h0000;
            return r;
        endfunction

        function out_item_t next_reply(in_item_t it);
            out_item_t r;
            r = '0;
            if (it.req_type == REQ_TICK) begin
                if (!link.joined) begin
                    r.tx_kind    = TX_HELLO;
                    r.tx_device  = HELLO_DEVICE;
                    r.tx_hw_type = regs.hw_type;
                    r.tx_version = regs.fw_version;
                end else if (link.retry_count > regs.retry_limit) begin
                    r.addr_action    = ADDR_RESTORE;
                    link.joined      = 1'b0;
                    link.retry_count = '0;
                end else begin
                    if ((it.switch_state != 8'h00 && link.retry_count[0])
                            || link.retry_count[1:0] == 2'b11) begin
                        r = with_ping(r, it.switch_state, it.current_measure);
                    end
                    if (link.retry_count != RETRY_MAX) begin
                        link.retry_count = link.retry_count + 8'd1;
                    end
                end
            end else begin
                case (it.msg_kind)
                    KIND_ACQUIRED: begin
                        link.device_id = it.msg_device;
                        r.addr_action  = ADDR_SET;
                        r.addr_value   = it.msg_addr & ADDR_MASK;
                        r.led_action   = LED_JOINED;
                        link.joined    = 1'b1;
                    end
                    KIND_PONG: begin
                        r.led_action     = LED_PONG;
                        link.retry_count = '0;
                    end
                    KIND_SWITCH: begin
                        r.switch_apply   = 1'b1;
                        link.retry_count = '0;
                        r = with_ping(r, it.switch_state, it.current_measure);
                    end
                    KIND_SETTINGS: begin
                        r.settings_apply = 1'b1;
                        link.retry_count = '0;
                        r = with_ping(r, it.switch_state, it.current_measure);
                    end
                    default: ;
                endcase
            end
            return r;
        endfunction

        function void note_request(in_item_t it);
            expected_replies.push_back(next_reply(it));
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 200) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
            end
        endtask

        task check_response(out_item_t got);
            out_item_t want;
            if (expected_replies.size() == 0) begin
                report("result transaction with no request pending");
                return;
            end
            want = expected_replies.pop_front();
            compare_field("tx_kind",        64'(got.tx_kind),        64'(want.tx_kind));
            compare_field("tx_device",      64'(got.tx_device),      64'(want.tx_device));
            compare_field("tx_hw_type",     64'(got.tx_hw_type),     64'(want.tx_hw_type));
            compare_field("tx_version",     64'(got.tx_version),     64'(want.tx_version));
            compare_field("tx_switch",      64'(got.tx_switch),      64'(want.tx_switch));
            compare_field("tx_measure",     64'(got.tx_measure),     64'(want.tx_measure));
            compare_field("addr_action",    64'(got.addr_action),    64'(want.addr_action));
            compare_field("addr_value",     64'(got.addr_value),     64'(want.addr_value));
            compare_field("led_action",     64'(got.led_action),     64'(want.led_action));
            compare_field("switch_apply",   64'(got.switch_apply),   64'(want.switch_apply));
            compare_field("settings_apply", 64'(got.settings_apply), 64'(want.settings_apply));
        endtask
    endclass

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    bit no_gaps = 1'b0;
    bit hold_rx = 1'b0;
    int stuck_cycles = 0;

    link_scoreboard sb = new();

    node_join_keepalive_fsm_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_response(m_data);
            end
            if (s_valid && s_ready) begin
                sb.note_request(s_data);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold on request
    initial begin : result_sink
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge aclk);
                hold_rx = 1'b0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 17);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic in_item_t make_request(logic req, logic [2:0] kind,
                                              logic [7:0] sw, logic [15:0] meas);
        in_item_t it;
        it.req_type        = req;
        it.msg_kind        = kind;
        it.msg_device      = 16'($urandom);
        it.msg_addr        = 40'({$urandom, $urandom});
        it.cmd_switch      = 8'($urandom);
        it.switch_state    = sw;
        it.current_measure = meas;
        return it;
    endfunction

    function automatic in_item_t random_request();
        int         pick;
        logic [7:0] sw;
        in_item_t   it;
        pick = $urandom_range(0, 99);
        sw   = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        if (pick < 55) begin
            it = make_request(REQ_TICK, 3'($urandom), sw, 16'($urandom));
        end else if (pick < 63) begin
            it = make_request(REQ_MSG, KIND_ACQUIRED, sw, 16'($urandom));
        end else if (pick < 75) begin
            it = make_request(REQ_MSG, KIND_PONG, sw, 16'($urandom));
        end else if (pick < 85) begin
            it = make_request(REQ_MSG, KIND_SWITCH, sw, 16'($urandom));
        end else if (pick < 93) begin
            it = make_request(REQ_MSG, KIND_SETTINGS, sw, 16'($urandom));
        end else begin
            it = make_request(REQ_MSG, 3'($urandom_range(4, 7)), sw, 16'($urandom));
        end
        if ($urandom_range(0, 15) == 0) begin
            it.msg_addr = '1;
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(logic [7:0] hw, logic [7:0] fw, logic [7:0] lim);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        idx = '{CFG_HW_TYPE, CFG_FW_VERSION, CFG_RETRY_LIMIT, CFG_UNUSED};
        val = '{hw, fw, lim, 8'($urandom)};
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        in_item_t   it;
        logic [7:0] lim;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration, unjoined
        send_item(make_request(REQ_TICK, 3'($urandom), 8'h00, 16'h0000));
        send_item(make_request(REQ_MSG, KIND_PONG, 8'hFF, 16'hFFFF));
        send_item(make_request(REQ_MSG, KIND_SWITCH, 8'hFF, 16'hFFFF));
        send_item(make_request(REQ_MSG, KIND_SETTINGS, 8'h00, 16'hFFFF));
        for (int k = 4; k < 8; k++) begin
            send_item(make_request(REQ_MSG, 3'(k), 8'($urandom), 16'($urandom)));
        end
        it = make_request(REQ_MSG, KIND_ACQUIRED, 8'h01, 16'h1234);
        it.msg_device = 16'hFFFF;
        it.msg_addr   = '1;
        send_item(it);
        // count up past the default limit, then drop
        for (int i = 0; i < 12; i++) begin
            send_item(make_request(REQ_TICK, 3'($urandom), i[0] ? 8'hFF : 8'h00,
                                   16'($urandom)));
        end
        send_item(make_request(REQ_TICK, 3'($urandom), 8'hFF, 16'hFFFF));
        it = make_request(REQ_MSG, KIND_ACQUIRED, 8'h00, 16'h0000);
        it.msg_device = 16'h0000;
        it.msg_addr   = '0;
        send_item(it);
        it = make_request(REQ_MSG, KIND_SWITCH, 8'h00, 16'h0000);
        it.cmd_switch = 8'h00;
        send_item(it);
        wait_drained();

        // retry count saturates, never drops
        program_regs(8'hF2, 8'h01, 8'hFF);
        no_gaps = 1'b1;
        send_item(make_request(REQ_MSG, KIND_ACQUIRED, 8'($urandom), 16'($urandom)));
        for (int i = 0; i < SAT_TICKS; i++) begin
            send_item(make_request(REQ_TICK, 3'($urandom), 8'($urandom), 16'($urandom)));
        end
        send_item(make_request(REQ_MSG, KIND_PONG, 8'($urandom), 16'($urandom)));
        send_item(make_request(REQ_TICK, 3'($urandom), 8'($urandom), 16'($urandom)));
        no_gaps = 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: program_regs(8'h00, 8'h00, 8'h00);
                1: program_regs(8'hFF, 8'hFF, 8'd254);
                default: begin
                    lim = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 254))
                                                      : 8'($urandom_range(0, 5));
                    program_regs(8'($urandom), 8'($urandom), lim);
                end
            endcase
            no_gaps = (ph == 3 || ph == 5);
            if (ph == 3) begin
                hold_rx = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_item(random_request());
            end
            no_gaps = 1'b0;
            wait_drained();
        end

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/njk_pkg.sv
rtl/njk_step.sv
rtl/node_join_keepalive_fsm_unit.sv
rtl/njk_checker.sv
tb/node_join_keepalive_fsm_unit_test.sv
